/* rtl/swm_pkg.sv */
// shared types and constants for the sliding window median core
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = DATA_W + 1;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    // broadcast to every cell of the sorted chain
    typedef struct packed {
        logic  update;    // request accepted, cells take their next value
        t_idx  evict;     // position removed from the sorted row
        t_idx  last_idx;  // last position of the row after the update
        t_idx  kmax;      // window length minus one, age of the oldest entry
        t_data sample;    // incoming sample
    } t_chain_ctl;

    // what a cell shows its neighbours
    typedef struct packed {
        t_data value;
        t_idx  age;
        logic  gt;        // stored value is greater than the incoming sample
        logic  hit;       // this cell holds the oldest entry of a full window
    } t_cell_out;

endpackage

`default_nettype wire

/* rtl/swm_cell.sv */
// one cell of the sorted chain: one window entry with its age
`default_nettype none

module swm_cell (
    input  wire logic               i_clk,
    input  wire swm_pkg::t_idx      i_idx,
    input  wire swm_pkg::t_chain_ctl i_ctl,
    input  wire swm_pkg::t_cell_out i_left,
    input  wire swm_pkg::t_cell_out i_right,
    output swm_pkg::t_cell_out      o_cell
);
    import swm_pkg::*;

    t_data r_value;
    t_data n_value;
    t_idx  r_age;
    t_idx  n_age;

    logic  lt_evict;
    logic  le_evict;
    logic  in_self;
    logic  in_left;
    logic  is_tail;
    logic  own_gt;
    t_data wv_self;
    t_data wv_left;
    t_idx  wa_self;
    t_idx  wa_left;
    logic  wg_self;
    logic  wg_left;

    assign own_gt = r_value > i_ctl.sample;

    always_comb begin
        lt_evict = i_idx < i_ctl.evict;
        le_evict = i_idx <= i_ctl.evict;
        in_self  = i_idx < i_ctl.last_idx;
        in_left  = (i_idx != '0) && (i_idx <= i_ctl.last_idx);
        is_tail  = i_idx == i_ctl.last_idx;

        // row with the evicted entry squeezed out
        wv_self = lt_evict ? r_value : i_right.value;
        wa_self = lt_evict ? r_age   : i_right.age;
        wg_self = lt_evict ? own_gt  : i_right.gt;
        wv_left = le_evict ? i_left.value : r_value;
        wa_left = le_evict ? i_left.age   : r_age;
        wg_left = le_evict ? i_left.gt    : own_gt;

        n_value = r_value;
        n_age   = r_age;
        if (in_left && wg_left) begin
            n_value = wv_left;
            n_age   = wa_left + t_idx'(1);
        end else if (is_tail || (in_self && wg_self)) begin
            n_value = i_ctl.sample;
            n_age   = '0;
        end else if (in_self) begin
            n_value = wv_self;
            n_age   = wa_self + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_cell.value = r_value;
    assign o_cell.age   = r_age;
    assign o_cell.gt    = own_gt;
    assign o_cell.hit   = (i_idx <= i_ctl.kmax) && (r_age == i_ctl.kmax);

endmodule

`default_nettype wire

/* rtl/sliding_window_median_core.sv */
// running median filter over a sliding window of signed samples
// result path: a producing request updates the sorted cell chain and sets the pending
//   flag; the middle sum then moves to the output register, which drives o_valid
// throughput: one request per cycle while results are taken, as each accepted request
//   updates the sorted cell chain on its own edge; with the output stalled one result waits in the
//   output register and one is pending, and further requests are held off
// reset: synchronous active-low, empties the window and sets window_size to 1;
//   cell contents are not cleared and are only read once written
`default_nettype none

module sliding_window_median_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire swm_pkg::t_cnt        i_cfg_wdata,
    // sample requests
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire swm_pkg::t_data       i_sample,
    input  wire logic                 i_last_sample,
    // results
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output swm_pkg::t_sum             o_median_sum,
    output logic                      o_sequence_end
);
    import swm_pkg::*;

    // window length register and the number of samples held
    t_cnt r_ws;
    t_cnt r_fill;
    t_cnt n_fill;

    // pending result: cells already updated, the sum is registered once the output is free or taken
    logic r_p_vld;
    logic r_p_last;
    // output register
    logic r_o_vld;
    logic r_o_last;
    t_sum r_o_sum;

    t_cnt       k_eff;
    t_idx       kmax;
    t_idx       mid_hi;
    t_idx       mid_lo;
    logic       full;
    logic       accept;
    logic       produce;
    logic       p_go;
    t_idx       evict_enc;
    t_data      lo_val;
    t_data      hi_val;
    t_chain_ctl ctl;
    t_cell_out  cells [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] hit_vec;

    // clamp window length to 1..WINDOW_MAX
    always_comb begin
        if (r_ws == '0) begin
            k_eff = t_cnt'(1);
        end else if (r_ws > t_cnt'(WINDOW_MAX)) begin
            k_eff = t_cnt'(WINDOW_MAX);
        end else begin
            k_eff = r_ws;
        end
    end

    assign kmax   = t_idx'(k_eff - t_cnt'(1));
    assign full   = r_fill == k_eff;
    assign accept = i_valid && o_ready;
    // a request yields a result once its own entry fills the window
    assign produce = full || ((r_fill + t_cnt'(1)) == k_eff);

    // the pending result moves on when the output register is free or being taken
    assign p_go    = r_p_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_p_vld || p_go;

    // position of the oldest entry, only one cell hits in a full window
    always_comb begin
        evict_enc = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (cells[i].hit) begin
                evict_enc = evict_enc | t_idx'(i);
            end
        end
    end

    // while filling, nothing leaves: the new entry goes at the end of the row
    always_comb begin
        ctl.update   = accept;
        ctl.evict    = full ? evict_enc : t_idx'(r_fill);
        ctl.last_idx = full ? kmax : t_idx'(r_fill);
        ctl.kmax     = kmax;
        ctl.sample   = i_sample;
    end

    // the sorted chain, each cell trades values with its neighbours
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_cell_out left_nb;
        t_cell_out right_nb;

        if (g == 0) begin : g_first
            assign left_nb = '0;
        end else begin : g_mid_l
            assign left_nb = cells[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_last
            assign right_nb = '0;
        end else begin : g_mid_r
            assign right_nb = cells[g+1];
        end

        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (t_idx'(g)),
            .i_ctl   (ctl),
            .i_left  (left_nb),
            .i_right (right_nb),
            .o_cell  (cells[g])
        );

        assign hit_vec[g] = cells[g].hit;
    end

    // middle positions, equal for an odd window
    assign mid_hi = t_idx'(k_eff >> 1);
    assign mid_lo = k_eff[0] ? mid_hi : mid_hi - t_idx'(1);

    // pick the two middle entries out of the row
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (t_idx'(i) == mid_lo) begin
                lo_val = lo_val | cells[i].value;
            end
            if (t_idx'(i) == mid_hi) begin
                hi_val = hi_val | cells[i].value;
            end
        end
    end

    // fill count: cleared by a configuration write or at the end of a sequence
    always_comb begin
        n_fill = r_fill;
        if (i_cfg_we) begin
            n_fill = '0;
        end else if (accept) begin
            if (i_last_sample) begin
                n_fill = '0;
            end else if (!full) begin
                n_fill = r_fill + t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= t_cnt'(1);
            r_fill  <= '0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            r_fill <= n_fill;

            if (accept && produce) begin
                r_p_vld <= 1'b1;
            end else if (p_go) begin
                r_p_vld <= 1'b0;
            end

            if (p_go) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_last <= i_last_sample;
        end
        if (p_go) begin
            r_o_sum  <= t_sum'(lo_val) + t_sum'(hi_val);
            r_o_last <= r_p_last;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_median_sum   = r_o_sum;
    assign o_sequence_end = r_o_last;

    // the window never holds more than its length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= k_eff)
        else $error("fill count above window length");

    // a full window has exactly one oldest entry
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full |-> $onehot(hit_vec))
        else $error("more than one oldest entry");

    // a producing request always leaves a pending result
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && produce |=> r_p_vld)
        else $error("result lost after request");

    // a pending result reaches a free output register in the next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld && !r_o_vld |=> r_o_vld)
        else $error("pending result did not advance");

    // requests are only held off behind a pending result
    a_hold_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_p_vld && r_o_vld)
        else $error("request held off without cause");

endmodule

`default_nettype wire

/* sim/sliding_window_median_core_tb.sv */
// self-checking testbench for the sliding window median core
`timescale 1ns / 1ps

module sliding_window_median_core_tb;
    import swm_pkg::*;

    // one expected median result
    typedef struct {
        t_sum median_sum;
        logic seq_end;
    } t_median_exp;

    // running window model and store of expected medians
    class median_scoreboard;
        t_cnt        window_reg;
        t_data       arrival_ring[WINDOW_MAX];
        t_data       sorted_row[WINDOW_MAX];
        int unsigned fill;
        int unsigned oldest;
        t_median_exp expected_medians[$];
        int unsigned requests;
        int unsigned results;
        int unsigned mismatches;

        function new();
            window_reg = t_cnt'(1);
            fill       = 0;
            oldest     = 0;
            requests   = 0;
            results    = 0;
            mismatches = 0;
        endfunction

        function void set_window(t_cnt value);
            window_reg = value;
            fill       = 0;
            oldest     = 0;
        endfunction

        function int unsigned window_len();
            if (window_reg == 0) return 1;
            if (window_reg > WINDOW_MAX) return WINDOW_MAX;
            return 32'(window_reg);
        endfunction

        function int unsigned pending();
            return expected_medians.size();
        endfunction

        function void note_request(t_data sample, logic last);
            int unsigned k;
            int unsigned n;
            int unsigned pos;
            int unsigned i;
            int unsigned j;
            t_data       evicted;
            t_sum        lo;
            t_sum        hi;
            t_median_exp exp_item;
            k = window_len();
            requests++;
            if (fill < k) begin
                n = fill;
                arrival_ring[fill] = sample;
                fill++;
            end else begin
                pos     = oldest % k;
                evicted = arrival_ring[pos];
                n       = fill;
                // drop one stored copy of the evicted value
                i = 0;
                while (i < n && sorted_row[i] != evicted) i++;
                if (i < n) begin
                    for (j = i; j + 1 < n; j++) sorted_row[j] = sorted_row[j + 1];
                    n--;
                end
                arrival_ring[pos] = sample;
                oldest = (pos + 1) % k;
                fill   = k;
            end
            i = n;
            while (i > 0 && sorted_row[i - 1] > sample) begin
                sorted_row[i] = sorted_row[i - 1];
                i--;
            end
            sorted_row[i] = sample;
            if (fill == k) begin
                hi = t_sum'(sorted_row[k / 2]);
                if (k % 2 == 1) lo = hi;
                else lo = t_sum'(sorted_row[k / 2 - 1]);
                exp_item.median_sum = lo + hi;
                exp_item.seq_end    = last;
                expected_medians    = {expected_medians, exp_item};
            end
            if (last) begin
                fill   = 0;
                oldest = 0;
            end
        endfunction

        function void check_result(t_sum median_sum, logic seq_end);
            t_median_exp exp_item;
            results++;
            if (expected_medians.size() == 0) begin
                $error("unexpected result: median_sum %0d, sequence_end %0b",
                       median_sum, seq_end);
                mismatches++;
                return;
            end
            exp_item = expected_medians.pop_front();
            if (median_sum !== exp_item.median_sum) begin
                $error("median_sum mismatch: expected %0d, actual %0d",
                       exp_item.median_sum, median_sum);
                mismatches++;
            end
            if (seq_end !== exp_item.seq_end) begin
                $error("sequence_end mismatch: expected %0b, actual %0b",
                       exp_item.seq_end, seq_end);
                mismatches++;
            end
        endfunction
    endclass

    localparam int    CLK_HALF       = 2;
    localparam int    RESET_CYCLES   = 6;
    // results pass the pending and output registers after the request, allow a little more
    localparam int    SETTLE_CYCLES  = 4;
    localparam int    RX_HOLD_CYCLES = 250;
    localparam int    IDLE_LIMIT     = 4000;
    localparam int    ITEM_TARGET    = 1500;
    localparam t_data S_MIN          = 32'h8000_0000;
    localparam t_data S_MAX          = 32'h7fff_ffff;

    // how random samples are drawn within one sequence
    typedef enum {MIX_WIDE, MIX_NARROW, MIX_EDGE} t_sample_mix;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_cnt  i_cfg_wdata;
    logic  i_valid;
    logic  o_ready;
    t_data i_sample;
    logic  i_last_sample;
    logic  o_valid;
    logic  i_ready;
    t_sum  o_median_sum;
    logic  o_sequence_end;

    median_scoreboard sb;
    bit               calm_phase;   // no idling on either side
    bit               rx_hold_req;  // ask the receiver for one long hold-off
    int unsigned      idle_cycles;
    int unsigned      settings_used;

    sliding_window_median_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_last_sample  (i_last_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_sum   (o_median_sum),
        .o_sequence_end (o_sequence_end)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // sample both handshakes at the rising edge, feed the model and the checker,
    // and watch for a hung pipeline
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_request(i_sample, i_last_sample);
            if (o_valid && i_ready) sb.check_result(o_median_sum, o_sequence_end);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sliding_window_median_core_tb failed");
                $finish;
            end
        end
    end

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin : receiver
        int unsigned run;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                // long hold so the core fills up and back-pressures its input
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (calm_phase) begin
                i_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) < 65) begin
                    i_ready <= 1'b1;
                    run = $urandom_range(1, 20);
                end else begin
                    i_ready <= 1'b0;
                    // mostly short stalls, now and then a long one
                    if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 3);
                    else run = $urandom_range(4, 40);
                end
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // gap before the next request, mostly none or short
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_phase) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic t_data pick_sample(input t_sample_mix mix);
        int narrow_v;
        case (mix)
            MIX_WIDE: begin
                return t_data'($urandom);
            end
            MIX_NARROW: begin
                // small spread so equal values meet in the window
                narrow_v = $urandom_range(0, 8);
                return t_data'(narrow_v - 4);
            end
            default: begin
                case ($urandom_range(0, 6))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return t_data'(0);
                    3:       return t_data'(-1);
                    4:       return S_MIN + 1;
                    5:       return S_MAX - 1;
                    default: return t_data'($urandom);
                endcase
            end
        endcase
    endfunction

    // drive one request and hold it until the core takes it
    task automatic send_sample(input t_data sample, input logic last);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_sample      <= sample;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_paced(input t_data sample, input logic last);
        send_sample(sample, last);
        sender_gap(pick_gap());
    endtask

    // stop offering and wait until every expected median is out, then let the
    // core settle in case the last request produced nothing
    task automatic drain_results();
        sender_gap(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the core idle
    task automatic write_window(input t_cnt value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_window(value);
        settings_used++;
    endtask

    initial begin : stimulus
        t_cnt        plan[$];
        int unsigned phase;
        int unsigned k;
        int unsigned seq_len;
        int unsigned idx;
        int unsigned seq_count;
        bit          close_seq;
        t_sample_mix mix;

        sb            = new();
        calm_phase    = 1'b0;
        rx_hold_req   = 1'b0;
        idle_cycles   = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of one: each request is its own median
        send_paced(S_MIN, 1'b0);
        send_paced(S_MAX, 1'b1);
        drain_results();

        // odd window, extremes of the sample range
        write_window(t_cnt'(3));
        send_paced(S_MAX, 1'b0);
        send_paced(S_MIN, 1'b0);
        send_paced(t_data'(0), 1'b0);
        send_paced(t_data'(-1), 1'b0);
        send_paced(S_MAX, 1'b1);
        drain_results();

        // sequence ends before the window fills, nothing comes out
        write_window(t_cnt'(4));
        send_paced(t_data'(5), 1'b0);
        send_paced(t_data'(6), 1'b1);
        drain_results();

        // even window, sums at both ends of the result range
        write_window(t_cnt'(2));
        send_paced(S_MAX, 1'b0);
        send_paced(S_MAX, 1'b0);
        send_paced(S_MIN, 1'b0);
        send_paced(S_MIN, 1'b1);
        drain_results();

        // equal values, eviction must drop only one copy
        write_window(t_cnt'(3));
        send_paced(t_data'(7), 1'b0);
        send_paced(t_data'(7), 1'b0);
        send_paced(t_data'(7), 1'b0);
        send_paced(t_data'(3), 1'b0);
        send_paced(t_data'(3), 1'b1);
        drain_results();

        // zero is raised to a window of one
        write_window(t_cnt'(0));
        send_paced(t_data'(-1), 1'b1);
        drain_results();

        // long output hold-off while requests keep coming back to back
        write_window(t_cnt'(5));
        calm_phase  = 1'b1;
        rx_hold_req = 1'b1;
        for (idx = 1; idx <= 40; idx++) send_paced(pick_sample(MIX_WIDE), idx == 40);
        calm_phase = 1'b0;
        drain_results();

        // random phases, the first ones hit the extremes of the register
        plan = '{t_cnt'(64), t_cnt'(127), t_cnt'(65), t_cnt'(1), t_cnt'(2), t_cnt'(0)};
        phase = 0;
        while (sb.requests < ITEM_TARGET) begin
            drain_results();
            if (phase < plan.size()) write_window(plan[phase]);
            else if ($urandom_range(0, 9) < 7) write_window(t_cnt'($urandom_range(1, 12)));
            else write_window(t_cnt'($urandom_range(0, 127)));
            calm_phase = ($urandom_range(0, 3) == 0);
            k = sb.window_len();
            seq_count = (k > 16) ? $urandom_range(1, 2) : $urandom_range(2, 5);
            repeat (seq_count) begin
                mix = t_sample_mix'($urandom_range(0, 2));
                // mostly sequences that fill the window, some broken off early
                if ($urandom_range(0, 99) < 80) seq_len = k + $urandom_range(0, 2 * k + 6);
                else seq_len = $urandom_range(1, k);
                // now and then the sequence runs on into the next one
                close_seq = ($urandom_range(0, 9) != 0);
                for (idx = 1; idx <= seq_len; idx++)
                    send_paced(pick_sample(mix), close_seq && idx == seq_len);
                // occasional pause until every median is out
                if ($urandom_range(0, 5) == 0) drain_results();
            end
            phase++;
        end
        calm_phase = 1'b0;

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d sample requests and %0d checked medians over %0d window settings",
                 sb.requests, sb.results, settings_used);
        $display("windows of 0, 1, 2, 64, 65 and 127, short sequences, repeats and a long stall");
        if (sb.mismatches == 0) begin
            $display("sliding_window_median_core_tb passed");
        end else begin
            $display("sliding_window_median_core_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_median_core.sv
sim/sliding_window_median_core_tb.sv
